>>> rtl/core/ptl_pkg.sv
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared constants and types for the page translation block with LRU
// replacement: field widths, table sizes and the table write request.
// ----------------------------------------------------------------------------
`default_nettype none

package ptl_pkg;

    localparam int VIRTUAL_PAGES  = 64;
    localparam int PHYS_FRAMES    = 32;
    localparam int WORDS_PER_PAGE = 1024;

    localparam int ADDR_W  = 16;
    localparam int PADDR_W = 15;
    localparam int PAGE_W  = $clog2(VIRTUAL_PAGES);
    localparam int FRAME_W = $clog2(PHYS_FRAMES);
    localparam int OFF_W   = $clog2(WORDS_PER_PAGE);
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 6;

    localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(PHYS_FRAMES);
    localparam logic [STAMP_W-1:0] STAMP_MAX    = {STAMP_W{1'b1}};

    // one write into the page table memories
    typedef struct packed {
        logic                frame_we;
        logic                stamp_we;
        logic [PAGE_W-1:0]   addr;
        logic [FRAME_W-1:0]  frame;
        logic [STAMP_W-1:0]  stamp;
    } ptl_tbl_wr_t;

endpackage

`default_nettype wire

>>> rtl/core/ptl_page_table.sv
// ----------------------------------------------------------------------------
// ptl_page_table
// Frame number and last-use stamp memories of the page table, one write
// port shared by both, one registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_page_table
    import ptl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire ptl_tbl_wr_t          wr,
    input  wire logic [PAGE_W-1:0]    frame_rd_addr,
    output logic      [FRAME_W-1:0]   frame_rd_data,
    input  wire logic [PAGE_W-1:0]    stamp_rd_addr,
    output logic      [STAMP_W-1:0]   stamp_rd_data
);

    logic [FRAME_W-1:0] frame_mem [VIRTUAL_PAGES];
    logic [STAMP_W-1:0] stamp_mem [VIRTUAL_PAGES];

    always_ff @(posedge aclk) begin
        if (wr.frame_we) begin
            frame_mem[wr.addr] <= wr.frame;
        end
        frame_rd_data <= frame_mem[frame_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr.stamp_we) begin
            stamp_mem[wr.addr] <= wr.stamp;
        end
        stamp_rd_data <= stamp_mem[stamp_rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/page_translate_lru_top.sv
// ----------------------------------------------------------------------------
// page_translate_lru_top
// Virtual to physical word address translation through a page table with
// least recently used replacement of resident pages.
// ----------------------------------------------------------------------------
// Path from input transaction to result: a hit passes lookup and fetch, a
// miss into a fresh frame goes from lookup to finish, a miss with eviction
// passes scan, victim read and victim load. Eviction time is set by the victim
// search: one stamp memory read and one compare per page entry, 64 entries.
// One request at a time; the next is taken once the result is registered.
// Synchronous active-low reset clears valid bits, frame count, request stamp
// and sets the frame limit to 32; table memories are not cleared.
`default_nettype none

module page_translate_lru_top
    import ptl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_W-1:0]     cfg_frames_in_use,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [ADDR_W-1:0]    s_virtual_address,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [PADDR_W-1:0]   m_physical_address,
    output logic      [FRAME_W-1:0]   m_frame_index,
    output logic                      m_was_hit,
    output logic                      m_did_evict,
    output logic      [PAGE_W-1:0]    m_evicted_page,
    output logic                      m_stamp_saturated
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LOOKUP = 7'b0000010,
        ST_FETCH  = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_VREAD  = 7'b0010000,
        ST_VLOAD  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CFG_W-1:0]           limit_cfg_reg, limit_cfg_next;
    logic [VIRTUAL_PAGES-1:0]   valid_reg, valid_next;
    logic [CFG_W-1:0]           alloc_reg, alloc_next;
    logic [STAMP_W-1:0]         stamp_reg, stamp_next;
    logic                       sat_reg, sat_next;
    logic [PAGE_W:0]            scan_cnt_reg, scan_cnt_next;
    logic                       cmp_en_reg, cmp_en_next;
    logic                       have_victim_reg, have_victim_next;
    logic                       m_valid_reg, m_valid_next;

    // payload, no reset
    logic [PAGE_W-1:0]          page_reg, page_next;
    logic [OFF_W-1:0]           offset_reg, offset_next;
    logic [PAGE_W-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [STAMP_W-1:0]         best_reg, best_next;
    logic [PAGE_W-1:0]          victim_reg, victim_next;
    logic [FRAME_W-1:0]         frame_reg, frame_next;
    logic                       hit_reg, hit_next;
    logic                       evict_reg, evict_next;
    logic [FRAME_W-1:0]         m_frame_reg, m_frame_next;
    logic [OFF_W-1:0]           m_offset_reg, m_offset_next;
    logic                       m_hit_reg, m_hit_next;
    logic                       m_evict_reg, m_evict_next;
    logic [PAGE_W-1:0]          m_evpage_reg, m_evpage_next;
    logic                       m_sat_reg, m_sat_next;

    logic [CFG_W-1:0]           frame_limit;
    logic                       s_fire;
    ptl_tbl_wr_t                tbl_wr;
    logic [PAGE_W-1:0]          frame_rd_addr;
    logic [FRAME_W-1:0]         frame_rd_data;
    logic [STAMP_W-1:0]         stamp_rd_data;

    ptl_page_table u_table (
        .aclk          (aclk),
        .wr            (tbl_wr),
        .frame_rd_addr (frame_rd_addr),
        .frame_rd_data (frame_rd_data),
        .stamp_rd_addr (scan_cnt_reg[PAGE_W-1:0]),
        .stamp_rd_data (stamp_rd_data)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        if (limit_cfg_reg == '0) begin
            frame_limit = CFG_W'(1);
        end else if (limit_cfg_reg > CFG_W'(PHYS_FRAMES)) begin
            frame_limit = CFG_W'(PHYS_FRAMES);
        end else begin
            frame_limit = limit_cfg_reg;
        end
    end

    assign frame_rd_addr = (state_reg == ST_LOOKUP) ? page_reg : victim_reg;

    always_comb begin
        state_next       = state_reg;
        limit_cfg_next   = limit_cfg_reg;
        valid_next       = valid_reg;
        alloc_next       = alloc_reg;
        stamp_next       = stamp_reg;
        sat_next         = sat_reg;
        scan_cnt_next    = scan_cnt_reg;
        cmp_en_next      = 1'b0;
        have_victim_next = have_victim_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        page_next        = page_reg;
        offset_next      = offset_reg;
        cmp_idx_next     = scan_cnt_reg[PAGE_W-1:0];
        best_next        = best_reg;
        victim_next      = victim_reg;
        frame_next       = frame_reg;
        hit_next         = hit_reg;
        evict_next       = evict_reg;
        m_frame_next     = m_frame_reg;
        m_offset_next    = m_offset_reg;
        m_hit_next       = m_hit_reg;
        m_evict_next     = m_evict_reg;
        m_evpage_next    = m_evpage_reg;
        m_sat_next       = m_sat_reg;
        tbl_wr           = '0;
        tbl_wr.addr      = page_reg;
        tbl_wr.frame     = frame_reg;
        tbl_wr.stamp     = stamp_reg;

        if (cfg_valid && cfg_ready) begin
            limit_cfg_next = cfg_frames_in_use;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    page_next   = s_virtual_address[OFF_W +: PAGE_W];
                    offset_next = s_virtual_address[OFF_W-1:0];
                    if (stamp_reg != STAMP_MAX) begin
                        stamp_next = stamp_reg + STAMP_W'(1);
                    end
                    sat_next   = (stamp_next == STAMP_MAX);
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                evict_next = 1'b0;
                if (valid_reg[page_reg]) begin
                    hit_next        = 1'b1;
                    tbl_wr.stamp_we = 1'b1;
                    state_next      = ST_FETCH;
                end else if (alloc_reg < frame_limit) begin
                    hit_next            = 1'b0;
                    frame_next          = alloc_reg[FRAME_W-1:0];
                    alloc_next          = alloc_reg + CFG_W'(1);
                    valid_next[page_reg] = 1'b1;
                    tbl_wr.frame_we     = 1'b1;
                    tbl_wr.stamp_we     = 1'b1;
                    tbl_wr.frame        = alloc_reg[FRAME_W-1:0];
                    state_next          = ST_FINISH;
                end else begin
                    hit_next         = 1'b0;
                    scan_cnt_next    = '0;
                    have_victim_next = 1'b0;
                    state_next       = ST_SCAN;
                end
            end
            ST_FETCH: begin
                frame_next = frame_rd_data;
                state_next = ST_FINISH;
            end
            ST_SCAN: begin
                // issue one stamp read per cycle, compare it in the next cycle
                if (scan_cnt_reg != (PAGE_W+1)'(VIRTUAL_PAGES)) begin
                    scan_cnt_next = scan_cnt_reg + (PAGE_W+1)'(1);
                    cmp_en_next   = 1'b1;
                end
                if (cmp_en_reg && valid_reg[cmp_idx_reg]
                        && (!have_victim_reg || stamp_rd_data < best_reg)) begin
                    best_next        = stamp_rd_data;
                    victim_next      = cmp_idx_reg;
                    have_victim_next = 1'b1;
                end
                if (scan_cnt_reg == (PAGE_W+1)'(VIRTUAL_PAGES) && !cmp_en_reg) begin
                    state_next = ST_VREAD;
                end
            end
            ST_VREAD: begin
                state_next = ST_VLOAD;
            end
            ST_VLOAD: begin
                if (have_victim_reg) begin
                    frame_next             = frame_rd_data;
                    evict_next             = 1'b1;
                    valid_next[victim_reg] = 1'b0;
                    tbl_wr.frame           = frame_rd_data;
                end else begin
                    frame_next   = '0;
                    tbl_wr.frame = '0;
                end
                valid_next[page_reg] = 1'b1;
                tbl_wr.frame_we      = 1'b1;
                tbl_wr.stamp_we      = 1'b1;
                state_next           = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_frame_next  = frame_reg;
                    m_offset_next = offset_reg;
                    m_hit_next    = hit_reg;
                    m_evict_next  = evict_reg;
                    m_evpage_next = evict_reg ? victim_reg : '0;
                    m_sat_next    = sat_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            limit_cfg_reg   <= FRAMES_RESET;
            valid_reg       <= '0;
            alloc_reg       <= '0;
            stamp_reg       <= '0;
            sat_reg         <= 1'b0;
            scan_cnt_reg    <= '0;
            cmp_en_reg      <= 1'b0;
            have_victim_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            limit_cfg_reg   <= limit_cfg_next;
            valid_reg       <= valid_next;
            alloc_reg       <= alloc_next;
            stamp_reg       <= stamp_next;
            sat_reg         <= sat_next;
            scan_cnt_reg    <= scan_cnt_next;
            cmp_en_reg      <= cmp_en_next;
            have_victim_reg <= have_victim_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg     <= page_next;
        offset_reg   <= offset_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_reg     <= best_next;
        victim_reg   <= victim_next;
        frame_reg    <= frame_next;
        hit_reg      <= hit_next;
        evict_reg    <= evict_next;
        m_frame_reg  <= m_frame_next;
        m_offset_reg <= m_offset_next;
        m_hit_reg    <= m_hit_next;
        m_evict_reg  <= m_evict_next;
        m_evpage_reg <= m_evpage_next;
        m_sat_reg    <= m_sat_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_physical_address = {m_frame_reg, m_offset_reg};
    assign m_frame_index      = m_frame_reg;
    assign m_was_hit          = m_hit_reg;
    assign m_did_evict        = m_evict_reg;
    assign m_evicted_page     = m_evpage_reg;
    assign m_stamp_saturated  = m_sat_reg;

endmodule

`default_nettype wire

>>> rtl/core/ptl_checker.sv
// ----------------------------------------------------------------------------
// ptl_checker
// Port-level checks on the translation results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_checker
    import ptl_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [PADDR_W-1:0]   m_physical_address,
    input wire logic [FRAME_W-1:0]   m_frame_index,
    input wire logic                 m_was_hit,
    input wire logic                 m_did_evict,
    input wire logic [PAGE_W-1:0]    m_evicted_page,
    input wire logic                 m_stamp_saturated
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_physical_address)
            && $stable(m_frame_index) && $stable(m_was_hit)
            && $stable(m_did_evict) && $stable(m_evicted_page)
            && $stable(m_stamp_saturated))
        else $error("stalled result changed");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_was_hit |-> !m_did_evict)
        else $error("hit reported an eviction");

    a_evpage_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_did_evict |-> m_evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    a_frame_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_physical_address[PADDR_W-1:OFF_W] == m_frame_index)
        else $error("physical address does not match frame");

endmodule

bind page_translate_lru_top ptl_checker u_ptl_checker (.*);

`default_nettype wire

>>> bench/page_translate_lru_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_translate_lru_top_tb
// Self-checking bench for the LRU page translation block. A scoreboard keeps
// its own page table, frame count and request stamp. It predicts every
// translation when the request is accepted, and it compares each returned
// transaction field by field. The stimulus runs through several frame limits,
// and both channels stall at random.
// ----------------------------------------------------------------------------
module page_translate_lru_top_tb;
    import ptl_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int DRAIN_CYCLES   = 80;
    localparam int TIMEOUT_CYCLES = 500_000;
    localparam int PHASE_ITEMS    = 94;
    localparam int N_PHASES       = 10;

    // frame limits for the random phases, out-of-range values included
    localparam logic [CFG_W-1:0] PHASE_LIMITS [N_PHASES] =
        '{6'd32, 6'd1, 6'd4, 6'd63, 6'd8, 6'd17, 6'd2, 6'd40, 6'd5, 6'd31};

    typedef struct packed {
        logic [PADDR_W-1:0] physical_address;
        logic [FRAME_W-1:0] frame_index;
        logic               was_hit;
        logic               did_evict;
        logic [PAGE_W-1:0]  evicted_page;
        logic               stamp_saturated;
    } translation_t;

    class translation_scoreboard;
        bit                 resident [VIRTUAL_PAGES];
        logic [FRAME_W-1:0] frame_of [VIRTUAL_PAGES];
        logic [STAMP_W-1:0] last_use [VIRTUAL_PAGES];
        int unsigned        frames_taken;
        logic [STAMP_W-1:0] stamp;
        logic [CFG_W-1:0]   frame_limit;
        translation_t       pending_translations [$];
        int                 errors;

        function new();
            foreach (resident[i]) begin
                resident[i] = 1'b0;
                frame_of[i] = '0;
                last_use[i] = '0;
            end
            frames_taken = 0;
            stamp        = '0;
            frame_limit  = FRAMES_RESET;
            errors       = 0;
        endfunction

        function void write_limit(input logic [CFG_W-1:0] value);
            frame_limit = value;
        endfunction

        function int unsigned usable_frames();
            if (frame_limit == 0)
                return 1;
            if (frame_limit > PHYS_FRAMES)
                return PHYS_FRAMES;
            return frame_limit;
        endfunction

        function void note_request(input logic [ADDR_W-1:0] vaddr);
            logic [PAGE_W-1:0] page;
            logic [OFF_W-1:0]  offset;
            translation_t      t;
            int                victim;
            page   = vaddr[ADDR_W-1:OFF_W];
            offset = vaddr[OFF_W-1:0];
            t      = '0;
            if (stamp != STAMP_MAX)
                stamp++;
            if (resident[page]) begin
                t.was_hit      = 1'b1;
                t.frame_index  = frame_of[page];
                last_use[page] = stamp;
            end else begin
                if (frames_taken < usable_frames()) begin
                    t.frame_index = FRAME_W'(frames_taken);
                    frames_taken++;
                end else begin
                    // oldest stamp wins, lowest page on ties
                    victim = -1;
                    foreach (resident[i]) begin
                        if (resident[i] && (victim < 0 || last_use[i] < last_use[victim]))
                            victim = i;
                    end
                    if (victim >= 0) begin
                        t.did_evict        = 1'b1;
                        t.evicted_page     = PAGE_W'(victim);
                        t.frame_index      = frame_of[victim];
                        resident[victim]   = 1'b0;
                    end
                end
                resident[page] = 1'b1;
                frame_of[page] = t.frame_index;
                last_use[page] = stamp;
            end
            t.physical_address = PADDR_W'({t.frame_index, offset});
            t.stamp_saturated  = (stamp == STAMP_MAX);
            pending_translations.push_back(t);
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task compare_field(input string name, input int unsigned got, input int unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
        endtask

        task check_result(input translation_t got);
            translation_t want;
            if (pending_translations.size() == 0) begin
                report_mismatch("result transaction with no request outstanding");
                return;
            end
            want = pending_translations.pop_front();
            compare_field("physical_address", got.physical_address, want.physical_address);
            compare_field("frame_index", got.frame_index, want.frame_index);
            compare_field("was_hit", got.was_hit, want.was_hit);
            compare_field("did_evict", got.did_evict, want.did_evict);
            compare_field("evicted_page", got.evicted_page, want.evicted_page);
            compare_field("stamp_saturated", got.stamp_saturated, want.stamp_saturated);
        endtask

        task check_drained();
            if (pending_translations.size() != 0)
                report_mismatch($sformatf("%0d translations never returned",
                                          pending_translations.size()));
        endtask
    endclass

    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 cfg_valid         = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_frames_in_use = '0;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic [ADDR_W-1:0]    s_virtual_address = '0;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic [PADDR_W-1:0]   m_physical_address;
    logic [FRAME_W-1:0]   m_frame_index;
    logic                 m_was_hit;
    logic                 m_did_evict;
    logic [PAGE_W-1:0]    m_evicted_page;
    logic                 m_stamp_saturated;

    translation_scoreboard sb;
    translation_t          seen;
    int                    idle_pct = 25;

    page_translate_lru_top DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_frames_in_use  (cfg_frames_in_use),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_virtual_address  (s_virtual_address),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_physical_address (m_physical_address),
        .m_frame_index      (m_frame_index),
        .m_was_hit          (m_was_hit),
        .m_did_evict        (m_did_evict),
        .m_evicted_page     (m_evicted_page),
        .m_stamp_saturated  (m_stamp_saturated)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // watch all three channels at the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_limit(cfg_frames_in_use);
            if (m_valid && m_ready) begin
                seen = {m_physical_address, m_frame_index, m_was_hit, m_did_evict,
                        m_evicted_page, m_stamp_saturated};
                sb.check_result(seen);
            end
            if (s_valid && s_ready)
                sb.note_request(s_virtual_address);
        end
    end

    // result side backpressure in bursts
    initial begin
        forever begin
            if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_request(input logic [ADDR_W-1:0] vaddr);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_virtual_address <= vaddr;
        do @(posedge aclk); while (!s_ready);
    endtask

    // first edge lets the monitor record the last accepted request
    task automatic wait_drained();
        do @(posedge aclk); while (sb.pending_translations.size() != 0);
    endtask

    task automatic write_frame_limit(input logic [CFG_W-1:0] value);
        s_valid <= 1'b0;
        wait_drained();
        cfg_valid         <= 1'b1;
        cfg_frames_in_use <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int                usable;
        int                base;
        int                span;
        logic [PAGE_W-1:0] page;
        logic [ADDR_W-1:0] vaddr;

        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // zero limit behaves as a single frame
        write_frame_limit(6'd0);
        send_request(16'h0000);
        send_request(16'h03FF);
        send_request(16'hFFFF);
        send_request(16'hFC00);
        send_request(16'h5555);

        // above the frame count clamps to all frames
        write_frame_limit(6'd63);
        send_request(16'hAAAA);
        send_request(16'h0000);
        send_request(16'h8001);
        send_request(16'h7FFE);
        send_request(16'h5555);
        send_request(16'hFFFF);

        // limit dropped under what is already allocated
        write_frame_limit(6'd2);
        send_request(16'h1111);
        send_request(16'h2222);
        send_request(16'h1111);
        send_request(16'h3333);
        send_request(16'hAAAA);

        for (int p = 0; p < N_PHASES; p++) begin
            write_frame_limit(PHASE_LIMITS[p]);
            if (p == N_PHASES - 1)
                idle_pct = 0;
            else
                idle_pct = $urandom_range(0, 3) * 12;
            if (PHASE_LIMITS[p] > PHYS_FRAMES)
                usable = PHYS_FRAMES;
            else
                usable = PHASE_LIMITS[p];
            base = $urandom_range(0, VIRTUAL_PAGES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // working set a little larger than the frame budget
                span = usable + $urandom_range(0, 4);
                if (span > VIRTUAL_PAGES)
                    span = VIRTUAL_PAGES;
                if (n % 30 == 29)
                    base = $urandom_range(0, VIRTUAL_PAGES - 1);
                if ($urandom_range(0, 6) == 0) begin
                    vaddr = ADDR_W'($urandom);
                end else begin
                    page  = PAGE_W'((base + $urandom_range(0, span - 1)) % VIRTUAL_PAGES);
                    vaddr = {page, OFF_W'($urandom)};
                end
                send_request(vaddr);
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("TB_ERROR");
        $finish;
    end

endmodule
